// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the bracket nesting checker.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/bnc_pkg.sv -----
// Package for the bracket nesting checker: sizes, codes, states, helpers.
// No dependencies; imported by bracket_nesting_checker_core.
`default_nettype none

package bnc_pkg;

  // Stack sizing
  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int KIND_W      = 2;

  // Field widths
  localparam int SYM_W    = 8;
  localparam int STATUS_W = 2;
  localparam int BAD_W    = 15;
  localparam int DONE_W   = 64;
  localparam int TOTAL_W  = 32;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CORRUPT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Bracket kinds
  localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

  // Character codes
  localparam logic [SYM_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [SYM_W-1:0] CH_LSQUARE = 8'h5B;
  localparam logic [SYM_W-1:0] CH_RSQUARE = 8'h5D;
  localparam logic [SYM_W-1:0] CH_LCURLY  = 8'h7B;
  localparam logic [SYM_W-1:0] CH_RCURLY  = 8'h7D;
  localparam logic [SYM_W-1:0] CH_LANGLE  = 8'h3C;
  localparam logic [SYM_W-1:0] CH_RANGLE  = 8'h3E;

  // Corrupt scores
  localparam logic [BAD_W-1:0] PTS_PAREN  = 15'd3;
  localparam logic [BAD_W-1:0] PTS_SQUARE = 15'd57;
  localparam logic [BAD_W-1:0] PTS_CURLY  = 15'd1197;
  localparam logic [BAD_W-1:0] PTS_ANGLE  = 15'd25137;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOP,
    ST_WALK,
    ST_EMIT
  } bnc_state_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } bnc_kind_t;

  // Decode an opening bracket
  function automatic bnc_kind_t opener_kind(input logic [SYM_W-1:0] c);
    bnc_kind_t k;
    k.hit  = 1'b1;
    k.kind = KIND_PAREN;
    case (c)
      CH_LPAREN:  k.kind = KIND_PAREN;
      CH_LSQUARE: k.kind = KIND_SQUARE;
      CH_LCURLY:  k.kind = KIND_CURLY;
      CH_LANGLE:  k.kind = KIND_ANGLE;
      default:    k.hit  = 1'b0;
    endcase
    return k;
  endfunction

  // Decode a closing bracket
  function automatic bnc_kind_t closer_kind(input logic [SYM_W-1:0] c);
    bnc_kind_t k;
    k.hit  = 1'b1;
    k.kind = KIND_PAREN;
    case (c)
      CH_RPAREN:  k.kind = KIND_PAREN;
      CH_RSQUARE: k.kind = KIND_SQUARE;
      CH_RCURLY:  k.kind = KIND_CURLY;
      CH_RANGLE:  k.kind = KIND_ANGLE;
      default:    k.hit  = 1'b0;
    endcase
    return k;
  endfunction

  // Score of an unmatched closer
  function automatic logic [BAD_W-1:0] bad_points(input logic [KIND_W-1:0] kind);
    logic [BAD_W-1:0] p;
    case (kind)
      KIND_PAREN:  p = PTS_PAREN;
      KIND_SQUARE: p = PTS_SQUARE;
      KIND_CURLY:  p = PTS_CURLY;
      KIND_ANGLE:  p = PTS_ANGLE;
      default:     p = PTS_PAREN;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bnc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the open-bracket stack of the checker core.
`default_nettype none

module bnc_ram #(
  parameter  int WIDTH  = 2,
  parameter  int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bracket_nesting_checker_core.sv -----
// Top level of the bracket nesting checker: line state, stack control, score unit.
// Depends on bnc_pkg, bnc_ram and assert_macros.svh.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_symbol, in_line_end
//   out_     output     out_valid / out_stall out_status, out_corrupt_score,
//                                             out_completion_score, out_corrupt_total
//
// A push, a fault or an ignored character is handled in ST_IDLE; a pop that is not
// a line end passes ST_TOP (the stack RAM read that reloads the cached top of stack).
// A corrupt or overflowed line end goes straight to ST_EMIT; a clean one first runs
// ST_WALK, which reads one stack entry per cycle through the single RAM read port and
// folds it into the score with one shared x5-plus-add unit. The result sits in an
// output register; a line end waits only if it is full and out_stall is high.
// Synchronous active-low reset clears the control state; the stack RAM needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module bracket_nesting_checker_core
  import bnc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SYM_W-1:0]    in_symbol,
  input  wire logic                in_line_end,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [BAD_W-1:0]    out_corrupt_score,
  output logic      [DONE_W-1:0]   out_completion_score,
  output logic      [TOTAL_W-1:0]  out_corrupt_total
);

  bnc_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    depth_r, depth_nxt;
  logic                corrupt_r, corrupt_nxt;
  logic                overflow_r, overflow_nxt;
  logic [BAD_W-1:0]    bad_r, bad_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [KIND_W-1:0]   top_r, top_nxt;
  logic [CNT_W-1:0]    walk_cnt_r, walk_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [DONE_W-1:0]   acc_r, acc_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [BAD_W-1:0]    res_bad_r, res_bad_nxt;
  logic                out_valid_r;
  logic                out_load;

  logic                accept;
  logic                do_pop;
  logic                do_walk;
  bnc_kind_t           ok_kind, ck_kind;
  logic [CNT_W-1:0]    depth_m2, walk_m1;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [KIND_W-1:0]   ram_wdata, ram_rdata;

  assign accept   = in_valid && !in_stall;
  assign ok_kind  = opener_kind(in_symbol);
  assign ck_kind  = closer_kind(in_symbol);
  assign depth_m2 = depth_r - CNT_W'(2);
  assign walk_m1  = walk_cnt_r - CNT_W'(1);
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // Open-bracket stack
  bnc_ram #(
    .WIDTH (KIND_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Line state update on an accepted request
  always_comb begin
    depth_nxt      = depth_r;
    corrupt_nxt    = corrupt_r;
    overflow_nxt   = overflow_r;
    bad_nxt        = bad_r;
    total_nxt      = total_r;
    top_nxt        = top_r;
    do_pop         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = depth_r[ADDR_W-1:0];
    ram_wdata      = ok_kind.kind;
    res_status_nxt = res_status_r;
    res_bad_nxt    = res_bad_r;
    if (accept) begin
      if (!corrupt_r && !overflow_r) begin
        if (ok_kind.hit) begin
          if (depth_r == CNT_W'(STACK_DEPTH)) begin
            overflow_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            depth_nxt = depth_r + CNT_W'(1);
            top_nxt   = ok_kind.kind;
          end
        end else if (ck_kind.hit) begin
          if (depth_r != '0 && top_r == ck_kind.kind) begin
            do_pop    = 1'b1;
            depth_nxt = depth_r - CNT_W'(1);
          end else begin
            corrupt_nxt = 1'b1;
            bad_nxt     = bad_points(ck_kind.kind);
            total_nxt   = total_r + TOTAL_W'(bad_points(ck_kind.kind));
          end
        end else begin
          corrupt_nxt = 1'b1;
          bad_nxt     = '0;
        end
      end
      // Capture the line verdict and drop the line state
      if (in_line_end) begin
        if (corrupt_nxt) begin
          res_status_nxt = STATUS_CORRUPT;
          res_bad_nxt    = bad_nxt;
        end else if (overflow_nxt) begin
          res_status_nxt = STATUS_OVERFLOW;
          res_bad_nxt    = '0;
        end else begin
          res_status_nxt = STATUS_OK;
          res_bad_nxt    = '0;
        end
        depth_nxt    = '0;
        corrupt_nxt  = 1'b0;
        overflow_nxt = 1'b0;
        bad_nxt      = '0;
      end
    end
  end

  assign do_walk = accept && in_line_end && (res_status_nxt == STATUS_OK);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_line_end) begin
            state_nxt = do_walk ? ST_WALK : ST_EMIT;
          end else if (do_pop) begin
            state_nxt = ST_TOP;
          end
        end
      end
      ST_TOP:  state_nxt = ST_IDLE;
      ST_WALK: begin
        if (walk_cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Stack reads, walk counter and score unit
  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    ram_re       = 1'b0;
    ram_raddr    = depth_m2[ADDR_W-1:0];
    walk_cnt_nxt = walk_cnt_r;
    pend_nxt     = 1'b0;
    acc_nxt      = acc_r;
    case (state_r)
      ST_IDLE: begin
        // Fetch the entry below the popped one as the new top
        ram_re = do_pop && !in_line_end;
        if (do_walk) begin
          walk_cnt_nxt = (ok_kind.hit && !corrupt_r && !overflow_r &&
                          depth_r != CNT_W'(STACK_DEPTH)) ? depth_r + CNT_W'(1) :
                         (do_pop ? depth_r - CNT_W'(1) : depth_r);
          acc_nxt      = '0;
        end
      end
      ST_TOP: ;
      ST_WALK: begin
        // Issue the next read from the top down
        if (walk_cnt_r != '0) begin
          ram_re       = 1'b1;
          ram_raddr    = walk_m1[ADDR_W-1:0];
          walk_cnt_nxt = walk_m1;
          pend_nxt     = 1'b1;
        end
        // Fold the entry read last cycle: acc * 5 + kind + 1
        if (pend_r) begin
          acc_nxt = (acc_r << 2) + acc_r + DONE_W'(ram_rdata) + DONE_W'(1);
        end
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      corrupt_r   <= 1'b0;
      overflow_r  <= 1'b0;
      bad_r       <= '0;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      depth_r    <= depth_nxt;
      corrupt_r  <= corrupt_nxt;
      overflow_r <= overflow_nxt;
      bad_r      <= bad_nxt;
      total_r    <= total_nxt;
      pend_r     <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    top_r        <= (state_r == ST_TOP) ? ram_rdata : top_nxt;
    walk_cnt_r   <= walk_cnt_nxt;
    acc_r        <= acc_nxt;
    res_status_r <= res_status_nxt;
    res_bad_r    <= res_bad_nxt;
    if (out_load) begin
      out_status           <= res_status_r;
      out_corrupt_score    <= res_bad_r;
      out_completion_score <= (res_status_r == STATUS_OK) ? acc_r : '0;
      out_corrupt_total    <= total_r;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  `ASSERT_CLK(a_depth_bound, clk, rst_n, depth_r <= CNT_W'(STACK_DEPTH))
  `ASSERT_CLK(a_fault_excl, clk, rst_n, !(corrupt_r && overflow_r))
  `ASSERT_CLK(a_out_from_emit, clk, rst_n, $rose(out_valid) |-> $past(state_r == ST_EMIT))
  `ASSERT_CLK(a_walk_bound, clk, rst_n, (state_r == ST_WALK) |-> (walk_cnt_r <= CNT_W'(STACK_DEPTH)))

endmodule

`default_nettype wire
